// ===== src/cbim_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbim_pkg
// Shared types and constants of the cartridge bank and IRQ mapper.
// ----------------------------------------------------------------------------
package cbim_pkg;

  // Command codes of an input item.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Register selects, taken from address bits 1:0 of a write.
  localparam logic [1:0] REG_PAGE   = 2'd0;
  localparam logic [1:0] REG_MIRROR = 2'd1;
  localparam logic [1:0] REG_IRQ    = 2'd2;

  // Address map.
  localparam logic [15:0] WinBase  = 16'h6000;
  localparam logic [15:0] BankBase = 16'h8000;
  localparam logic [15:0] RegBase  = 16'hE000;

  // Reset value of the page count.
  localparam logic [8:0] PagesReset = 9'd16;

  // IRQ counter and prescaler.
  localparam logic [15:0] IrqCompare  = 16'h6000;
  localparam int unsigned PrescaleDiv = 3;

  // Division by the prescaler ratio as a multiply by a scaled reciprocal.
  // The estimate is exact for every sum of prescaler and tick count.
  localparam int unsigned RecipShift = 9;
  localparam int unsigned Recip      = (2 ** RecipShift + PrescaleDiv - 1) / PrescaleDiv;

  // Restoring remainder steps, one per bit of the written byte.
  localparam int unsigned DivSteps = 8;
  localparam int unsigned CntW     = $clog2(DivSteps);

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] bus_address;
    logic [7:0]  write_value;
    logic [7:0]  tick_cycles;
  } cbim_in_t;

  typedef struct packed {
    logic [20:0] rom_offset;
    logic        read_handled;
    logic        mirror_horizontal;
    logic        irq_line;
  } cbim_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV
  } cbim_state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic div_step;
    logic div_last;
  } cbim_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_write;
  } cbim_sts_t;

endpackage

// ===== src/cartridge_bank_and_irq_mapper_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_and_irq_mapper_top
// Cartridge mapper with an 8K ROM page window, a fixed last 32K bank,
// mirroring control and a prescaled IRQ counter.
// ----------------------------------------------------------------------------
// An item is taken into the exec state. For reads, ticks and most writes, done_o
// and the result are registered at the end of exec. A page select write runs
// the eight remainder steps after exec, and its result is registered at the end
// of the last step. A new item is not taken before the last one is through;
// busy is low again in the cycle of the strobe, so the next item can go then.
// Reset clears all mapper state and loads a page count of sixteen.
// Results cannot be stalled: done_o is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module cartridge_bank_and_irq_mapper_top
  import cbim_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // Item channel: an item is taken at an edge with start high and busy low.
  input  logic       start,
  output logic       busy,
  input  cbim_in_t   item_i,
  // Result channel: one cycle strobe, no back pressure.
  output logic       done_o,
  output cbim_out_t  result_o,
  // Page count register write channel.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [8:0] cfg_data_i
);

  cbim_cmd_t cmd;
  cbim_sts_t sts;
  logic      ctrl_busy;

  // The controller owns sequencing; the datapath owns every piece of mapper
  // state and computes the result from the state as it stands after the item.
  cbim_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (ctrl_busy)
  );

  cbim_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  assign busy = ctrl_busy;

  // The page count is only taken while no item is in flight.
  assign cfg_ready_o = !ctrl_busy;

endmodule

// ===== src/cbim_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbim_ctrl
// Sequencer: takes an item, runs it in the exec state, and runs the remainder
// steps of a page select write.
// ----------------------------------------------------------------------------
module cbim_ctrl
  import cbim_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  cbim_sts_t sts_i,
  output cbim_cmd_t cmd_o,
  output logic      busy_o
);

  cbim_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic last_step;

  assign last_step = (cnt_q == CntW'(DivSteps - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cnt_d = '0;
        if (sts_i.div_write) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (last_step) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_last = last_step;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  a_exec_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && !sts_i.div_write) |=> (state_q == ST_IDLE))
    else $error("plain item did not finish after one cycle");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && last_step) |=> (state_q == ST_IDLE))
    else $error("remainder sequence overran its step count");

endmodule

// ===== src/cbim_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbim_dpath
// Mapper state, address translation, IRQ counter and the serial remainder
// unit for page select writes.
// ----------------------------------------------------------------------------
module cbim_dpath
  import cbim_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cbim_in_t  item_i,
  input  cbim_cmd_t cmd_i,
  output cbim_sts_t sts_o,
  input  logic      cfg_we_i,
  input  logic [8:0] cfg_data_i,
  output logic      done_o,
  output cbim_out_t result_o
);

  cbim_in_t  item_q;
  cbim_out_t res_q, res_d;
  logic      done_q, done_d;

  logic [8:0]  pages_q;
  logic [7:0]  page_q, page_d;
  logic        mirror_q, mirror_d;
  logic        irq_on_q, irq_on_d;
  logic        raised_q, raised_d;
  logic [15:0] counter_q, counter_d;
  logic [1:0]  prescale_q, prescale_d;

  // Remainder unit.
  logic [8:0]  rem_q, rem_d;
  logic [7:0]  dvd_q, dvd_d;
  logic [9:0]  div_trial;
  logic        div_fit;
  logic [8:0]  rem_next;

  // Decode of the held item.
  logic is_read, is_write, is_tick, reg_hit;
  logic [6:0] banks, last_bank;

  // Tick arithmetic.
  logic [8:0]  tick_total;
  logic [17:0] tick_prod;
  logic [8:0]  tick_steps;
  logic [1:0]  tick_rem;
  logic [15:0] irq_gap;
  logic        irq_hit;

  logic finish;

  assign is_read  = (item_q.command == CMD_READ);
  assign is_write = (item_q.command == CMD_WRITE);
  assign is_tick  = (item_q.command == CMD_TICK);
  assign reg_hit  = is_write && (item_q.bus_address >= RegBase);

  assign sts_o.div_write = reg_hit && (item_q.bus_address[1:0] == REG_PAGE)
                           && (pages_q != 9'd0);

  assign banks     = pages_q[8:2];
  assign last_bank = (banks == 7'd0) ? 7'd0 : banks - 7'd1;

  assign tick_total = {7'd0, prescale_q} + {1'b0, item_q.tick_cycles};
  assign tick_prod  = 18'(tick_total) * 18'(Recip);
  assign tick_steps = tick_prod[RecipShift +: 9];
  assign tick_rem   = 2'(tick_total - 9'(tick_steps * 9'(PrescaleDiv)));
  // One less than the steps needed from the current count to reach the compare value.
  assign irq_gap    = IrqCompare - counter_q - 16'd1;
  assign irq_hit    = ({7'd0, tick_steps} > irq_gap);

  assign div_trial = {rem_q, dvd_q[7]};
  assign div_fit   = (div_trial >= {1'b0, pages_q});
  assign rem_next  = div_fit ? 9'(div_trial - {1'b0, pages_q}) : div_trial[8:0];

  assign finish = (cmd_i.exec && !sts_o.div_write) || cmd_i.div_last;

  // State updates.
  always_comb begin
    page_d     = page_q;
    mirror_d   = mirror_q;
    irq_on_d   = irq_on_q;
    raised_d   = raised_q;
    counter_d  = counter_q;
    prescale_d = prescale_q;
    rem_d      = rem_q;
    dvd_d      = dvd_q;
    if (cmd_i.exec) begin
      if (reg_hit) begin
        case (item_q.bus_address[1:0])
          REG_PAGE: begin
            page_d = 8'd0;
            rem_d  = 9'd0;
            dvd_d  = item_q.write_value;
            if (pages_q != 9'd0) begin
              page_d = page_q;
            end
          end
          REG_MIRROR: begin
            mirror_d = item_q.write_value[3];
          end
          REG_IRQ: begin
            irq_on_d = item_q.write_value[1];
            if (!item_q.write_value[1]) begin
              counter_d = 16'd0;
              raised_d  = 1'b0;
            end
          end
          default: begin
            page_d = page_q;
          end
        endcase
      end else if (is_tick && irq_on_q) begin
        counter_d  = counter_q + 16'(tick_steps);
        raised_d   = raised_q || irq_hit;
        prescale_d = tick_rem;
      end
    end
    if (cmd_i.div_step) begin
      rem_d = rem_next;
      dvd_d = {dvd_q[6:0], 1'b0};
      if (cmd_i.div_last) begin
        page_d = rem_next[7:0];
      end
    end
  end

  // Result from the state as it stands after the item.
  always_comb begin
    res_d                   = '0;
    res_d.mirror_horizontal = mirror_d;
    res_d.irq_line          = raised_d;
    if (is_read) begin
      if (item_q.bus_address >= BankBase) begin
        res_d.rom_offset   = {last_bank[5:0], item_q.bus_address[14:0]};
        res_d.read_handled = 1'b1;
      end else if (item_q.bus_address >= WinBase) begin
        res_d.rom_offset   = {page_q, item_q.bus_address[12:0]};
        res_d.read_handled = 1'b1;
      end
    end
    done_d = finish;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_q    <= PagesReset;
      page_q     <= '0;
      mirror_q   <= 1'b0;
      irq_on_q   <= 1'b0;
      raised_q   <= 1'b0;
      counter_q  <= '0;
      prescale_q <= '0;
      done_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pages_q <= cfg_data_i;
      end
      page_q     <= page_d;
      mirror_q   <= mirror_d;
      irq_on_q   <= irq_on_d;
      raised_q   <= raised_d;
      counter_q  <= counter_d;
      prescale_q <= prescale_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
    if (finish) begin
      res_q <= res_d;
    end
    rem_q <= rem_d;
    dvd_q <= dvd_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  a_raise_needs_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    raised_q |-> irq_on_q)
    else $error("IRQ raised while disabled");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !irq_on_q |-> (counter_q == 16'd0))
    else $error("IRQ counter moved while disabled");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("result strobe held for two cycles");

endmodule
